// ----- hdl/gab_pkg.sv -----
// gab_pkg: shared types, register codes and limit functions for the glyph blit
// used by every module of glyph_alpha_blit; no dependencies
`timescale 1ns / 1ps

package gab_pkg;

	localparam int FRAME_MAX = 4096;
	localparam int GLYPH_MAX = 255;

	localparam int CNT_W   = 8;
	localparam int POS_W   = 13;
	localparam int BASE_W  = 26;
	localparam int ADDR_W  = 24;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 32;
	localparam int QDEPTH  = 2;

	localparam logic [IDX_W-1:0] REG_DEST_X       = 3'd0;
	localparam logic [IDX_W-1:0] REG_DEST_Y       = 3'd1;
	localparam logic [IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd2;
	localparam logic [IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd3;
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;
	localparam logic [IDX_W-1:0] REG_TINT_COLOR   = 3'd6;

	typedef struct packed {
		logic [11:0]      dest_x;
		logic [11:0]      dest_y;
		logic [7:0]       glyph_w;
		logic [7:0]       glyph_h;
		logic [POS_W-1:0] frame_w;
		logic [POS_W-1:0] frame_h;
		logic [31:0]      tint;
	} cfg_t;

	typedef struct packed {
		logic              in_frame;
		logic              last;
		logic [POS_W-1:0]  x;
		logic [BASE_W-1:0] row_base;
		logic [7:0]        alpha;
		logic [31:0]       dst;
	} item_t;

	function automatic logic [7:0] limit_glyph(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		if (v == 8'd0)
			r = 8'd1;
		else if (int'(v) > GLYPH_MAX)
			r = 8'(GLYPH_MAX);
		return r;
	endfunction

	function automatic logic [POS_W-1:0] limit_frame(input logic [POS_W-1:0] v);
		logic [POS_W-1:0] r;
		r = v;
		if (int'(v) > FRAME_MAX)
			r = POS_W'(FRAME_MAX);
		return r;
	endfunction

endpackage

// ----- hdl/gab_front.sv -----
// gab_front: raster counters, clipping, address row base and effective alpha
// depends on gab_pkg; feeds gab_queue
`timescale 1ns / 1ps

module gab_front (
	input  logic            clk,
	input  logic            arst_n,
	input  gab_pkg::cfg_t   cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      coverage,
	input  logic [31:0]     dst_pixel,
	input  logic            full,
	output logic            push,
	output gab_pkg::item_t  push_item
);
	import gab_pkg::*;

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [7:0]       gw;
	logic [7:0]       gh;
	logic [POS_W-1:0] fw;
	logic [POS_W-1:0] fh;
	logic [POS_W-1:0] x;
	logic [POS_W-1:0] y;
	logic [CNT_W:0]   col_inc;
	logic [CNT_W:0]   row_inc;
	logic             col_end;
	logic             row_end;
	logic [15:0]      a_prod;

	assign gw = limit_glyph(cfg.glyph_w);
	assign gh = limit_glyph(cfg.glyph_h);
	assign fw = limit_frame(cfg.frame_w);
	assign fh = limit_frame(cfg.frame_h);

	assign x       = POS_W'(cfg.dest_x) + POS_W'(col_q);
	assign y       = POS_W'(cfg.dest_y) + POS_W'(row_q);
	assign col_inc = {1'b0, col_q} + 9'd1;
	assign row_inc = {1'b0, row_q} + 9'd1;
	assign col_end = col_inc >= {1'b0, gw};
	assign row_end = row_inc >= {1'b0, gh};
	assign a_prod  = 16'(coverage) * 16'(cfg.tint[7:0]);

	assign in_ready = !full;
	assign push     = in_valid && !full;

	always_comb begin
		push_item.in_frame = (x < fw) && (y < fh);
		push_item.last     = col_end && row_end;
		push_item.x        = x;
		push_item.row_base = BASE_W'(y) * BASE_W'(fw);
		push_item.alpha    = a_prod[15:8];
		push_item.dst      = dst_pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_inc[CNT_W-1:0];
			end else begin
				col_q <= col_inc[CNT_W-1:0];
			end
		end
	end

endmodule

// ----- hdl/gab_queue.sv -----
// gab_queue: two-entry register queue between front and back
// depends on gab_pkg
`timescale 1ns / 1ps

module gab_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gab_pkg::item_t  push_item,
	input  logic            pop,
	output logic            full,
	output logic            nonempty,
	output gab_pkg::item_t  head
);
	import gab_pkg::*;

	item_t       entry_q [QDEPTH];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full     = count_q == 2'(QDEPTH);
	assign nonempty = count_q != 2'd0;
	assign head     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

// ----- hdl/gab_back.sv -----
// gab_back: channel blend in two stages with the result register
// depends on gab_pkg; drains gab_queue
`timescale 1ns / 1ps

module gab_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gab_pkg::cfg_t              cfg,
	input  logic                       nonempty,
	input  gab_pkg::item_t             head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       write_enable,
	output logic [gab_pkg::ADDR_W-1:0] address,
	output logic [31:0]                pixel,
	output logic                       last
);
	import gab_pkg::*;

	logic              valid_s1;
	logic              in_frame_s1;
	logic              last_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        dst_a_s1;
	logic [23:0]       src_prod_s1 [3];
	logic [15:0]       dst_prod_s1 [3];

	logic [23:0]       src_prod [3];
	logic [15:0]       dst_prod [3];
	logic [7:0]        chan [3];
	logic              adv_s1;

	assign adv_s1 = !out_valid || out_ready;
	assign pop    = nonempty && (!valid_s1 || adv_s1);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			src_prod[i] = 24'({cfg.tint[31-8*i -: 8], 8'd0} - 16'(cfg.tint[31-8*i -: 8]))
				* 24'(head.alpha);
			dst_prod[i] = 16'(head.dst[31-8*i -: 8]) * 16'(8'd255 - head.alpha);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			chan[i] = src_prod_s1[i][23:16] + dst_prod_s1[i][15:8];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			in_frame_s1 <= head.in_frame;
			last_s1     <= head.last;
			addr_s1     <= ADDR_W'(head.row_base + BASE_W'(head.x));
			dst_a_s1    <= head.dst[7:0];
			for (int i = 0; i < 3; i++) begin
				src_prod_s1[i] <= src_prod[i];
				dst_prod_s1[i] <= dst_prod[i];
			end
		end
		if (valid_s1 && adv_s1) begin
			write_enable <= in_frame_s1;
			last         <= last_s1;
			address      <= in_frame_s1 ? addr_s1 : '0;
			pixel        <= in_frame_s1 ? {chan[0], chan[1], chan[2], dst_a_s1} : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (pop)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				out_valid <= valid_s1;
		end
	end

endmodule

// ----- hdl/glyph_alpha_blit.sv -----
// glyph_alpha_blit: top level with configuration registers, front, queue and back
// depends on gab_pkg, gab_front, gab_queue, gab_back
`timescale 1ns / 1ps

// Tinted alpha blit of one glyph coverage map into an RGBA8888 frame. Feed one
// coverage byte per beat in raster order over the glyph rectangle, together with
// the frame word at that spot; each beat returns exactly one result with the
// word address, the blended pixel, a write enable that is low for clipped
// positions (address and pixel then read zero) and last on the final pixel.
// The block sustains one beat per clock while out_ready is high. Each beat is
// registered in the queue and in the back end's per-channel multiply and
// result stages. A two-entry queue lets input keep flowing while a result waits.
// Write the configuration registers only while nothing is in flight; writes do
// not touch the raster counters.

module glyph_alpha_blit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [gab_pkg::IDX_W-1:0]  cfg_index,
	input  logic [gab_pkg::DATA_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 coverage,
	input  logic [31:0]                dst_pixel,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       write_enable,
	output logic [gab_pkg::ADDR_W-1:0] address,
	output logic [31:0]                pixel,
	output logic                       last
);
	import gab_pkg::*;

	cfg_t  cfg_q;
	item_t push_item;
	item_t head;
	logic  push;
	logic  pop;
	logic  full;
	logic  nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_x  <= '0;
			cfg_q.dest_y  <= '0;
			cfg_q.glyph_w <= 8'd1;
			cfg_q.glyph_h <= 8'd1;
			cfg_q.frame_w <= POS_W'(1);
			cfg_q.frame_h <= POS_W'(1);
			cfg_q.tint    <= '1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEST_X:       cfg_q.dest_x  <= cfg_data[11:0];
				REG_DEST_Y:       cfg_q.dest_y  <= cfg_data[11:0];
				REG_GLYPH_WIDTH:  cfg_q.glyph_w <= cfg_data[7:0];
				REG_GLYPH_HEIGHT: cfg_q.glyph_h <= cfg_data[7:0];
				REG_FRAME_WIDTH:  cfg_q.frame_w <= cfg_data[POS_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_h <= cfg_data[POS_W-1:0];
				REG_TINT_COLOR:   cfg_q.tint    <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	gab_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.coverage  (coverage),
		.dst_pixel (dst_pixel),
		.full      (full),
		.push      (push),
		.push_item (push_item)
	);

	gab_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (full),
		.nonempty  (nonempty),
		.head      (head)
	);

	gab_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.nonempty     (nonempty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_enable (write_enable),
		.address      (address),
		.pixel        (pixel),
		.last         (last)
	);

endmodule

// ----- hdl/gab_checker.sv -----
// gab_checker: port-level checks on glyph_alpha_blit, bound to the top level
// depends on gab_pkg
`timescale 1ns / 1ps

module gab_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       write_enable,
	input logic [gab_pkg::ADDR_W-1:0] address,
	input logic [31:0]                pixel,
	input logic                       last
);
	import gab_pkg::*;

	logic [2:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (in_beat && !out_beat)
			pending_q <= pending_q + 3'd1;
		else if (out_beat && !in_beat)
			pending_q <= pending_q - 3'd1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel) && $stable(address)
			&& $stable(last) && $stable(write_enable))
		else $error("result changed while stalled");

	a_clip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> address == '0 && pixel == '0)
		else $error("clipped result carries address or pixel");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result without an accepted beat");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("more beats in flight than storage");

endmodule

bind glyph_alpha_blit gab_checker u_gab_checker (.*);
